FILE: rtl/i2cdbw_pkg.sv
// ============================================================================
// I2C display byte writer - shared package
// Types, register indexes and byte constants used by the writer modules.
// ============================================================================
package i2cdbw_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_ADDRESS_BYTE = 2'd0;
    localparam logic [1:0] REG_PHASE_TICKS  = 2'd1;

    // Reset values of the configuration registers
    localparam logic [7:0] ADDRESS_BYTE_RST = 8'h78;
    localparam logic [7:0] PHASE_TICKS_RST  = 8'd7;

    // Control bytes sent ahead of the payload
    localparam logic [7:0] CTRL_COMMAND = 8'h00;
    localparam logic [7:0] CTRL_DATA    = 8'h40;

    // Bits per byte on the bus
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Index of the last byte of a transaction (address, control, payload)
    localparam logic [1:0] LAST_BYTE = 2'd2;

    // One input item
    typedef struct packed {
        logic       sda_in;
        logic       is_data;
        logic [7:0] payload;
        logic       mode;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic nack;
        logic done_res;
        logic busy_res;
        logic sda_level;
        logic scl_level;
    } out_item_t;

    // Configuration write
    typedef struct packed {
        logic       we;
        logic [1:0] index;
        logic [7:0] data;
    } cfg_write_t;

endpackage

FILE: rtl/i2c_display_byte_writer.sv
// Results are registered in the output register, or in the skid if the output is held.
// Throughput: one item per cycle unless the skid is full; one sequencer step per item.
// A two-entry output stage (register plus skid) keeps input ready while a result waits.
// Reset (rst_n low, asynchronous): bus idle, nack clear, registers 0x78 and 7.
// ============================================================================
// I2C display byte writer - top level
// Bit-level I2C master writing address, control and payload bytes per
// transaction, one line-level result per input item.
// ============================================================================
module i2c_display_byte_writer
    import i2cdbw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [7:0] payload, [8] is_data, [9] sda_in, [15:10] zero
    input  logic        s_tuser,    // [0] mode
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata     // [0] scl_level, [1] sda_level, [2] busy_res,
                                    // [3] done_res, [4] nack, [7:5] zero
);

    cfg_write_t cfg;
    in_item_t   item;
    out_item_t  result;
    out_item_t  out_item;
    logic       accept;

    assign cfg_ready = 1'b1;
    assign cfg.we    = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // Unpack the input transfer
    assign item.mode    = s_tuser;
    assign item.payload = s_tdata[7:0];
    assign item.is_data = s_tdata[8];
    assign item.sda_in  = s_tdata[9];

    assign accept = s_tvalid && s_tready;

    i2cdbw_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (accept),
        .item       (item),
        .result     (result)
    );

    i2cdbw_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .can_push  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_item)
    );

    // Pack the result transfer
    assign m_tdata = {3'b000, out_item.nack, out_item.done_res, out_item.busy_res,
                      out_item.sda_level, out_item.scl_level};

`ifndef SYNTHESIS
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> m_tdata[2])
        else $error("done without busy");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted item produced no result");
`endif

endmodule

FILE: rtl/i2cdbw_core.sv
// ============================================================================
// I2C display byte writer - bus sequencer
// Holds the bus state and, for each accepted item, steps it and forms the
// line levels and status of the result in the same cycle.
// ============================================================================
module i2cdbw_core
    import i2cdbw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_write_t cfg,
    input  logic       item_valid,
    input  in_item_t   item,
    output out_item_t  result
);

    typedef enum logic [12:0] {
        PH_IDLE     = 13'b0000000000001,
        PH_START_A  = 13'b0000000000010,
        PH_START_B  = 13'b0000000000100,
        PH_START_C  = 13'b0000000001000,
        PH_BIT_SET  = 13'b0000000010000,
        PH_BIT_HIGH = 13'b0000000100000,
        PH_BIT_LOW  = 13'b0000001000000,
        PH_ACK_SET  = 13'b0000010000000,
        PH_ACK_HIGH = 13'b0000100000000,
        PH_ACK_LOW  = 13'b0001000000000,
        PH_STOP_A   = 13'b0010000000000,
        PH_STOP_B   = 13'b0100000000000,
        PH_STOP_C   = 13'b1000000000000
    } phase_t;

    phase_t     phase_reg,        phase_next;
    logic [1:0] byte_index_reg,   byte_index_next;
    logic [3:0] bit_count_reg,    bit_count_next;
    logic [7:0] shift_reg,        shift_next;
    logic [7:0] wait_count_reg,   wait_count_next;
    logic [8:0] held_payload_reg, held_payload_next;
    logic       nack_flag_reg,    nack_flag_next;
    logic [7:0] address_byte_reg;
    logic [7:0] phase_ticks_reg;

    logic       scl_lvl;
    logic       sda_lvl;
    logic       active;
    logic [7:0] limit;
    logic [7:0] wait_inc;
    logic [3:0] bit_inc;
    logic [1:0] byte_inc;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_byte_reg <= ADDRESS_BYTE_RST;
            phase_ticks_reg  <= PHASE_TICKS_RST;
        end
        else if (cfg.we)
        begin
            case (cfg.index)
                REG_ADDRESS_BYTE: address_byte_reg <= cfg.data;
                REG_PHASE_TICKS:  phase_ticks_reg  <= cfg.data;
                default:          ;
            endcase
        end
    end

    // Line levels of the current phase
    always_comb
    begin
        active = 1'b1;
        case (phase_reg)
            PH_START_A:  begin scl_lvl = 1'b1; sda_lvl = 1'b1;         end
            PH_START_B:  begin scl_lvl = 1'b1; sda_lvl = 1'b0;         end
            PH_START_C:  begin scl_lvl = 1'b0; sda_lvl = 1'b0;         end
            PH_BIT_SET:  begin scl_lvl = 1'b0; sda_lvl = shift_reg[7]; end
            PH_BIT_HIGH: begin scl_lvl = 1'b1; sda_lvl = shift_reg[7]; end
            PH_BIT_LOW:  begin scl_lvl = 1'b0; sda_lvl = shift_reg[7]; end
            PH_ACK_SET:  begin scl_lvl = 1'b0; sda_lvl = 1'b1;         end
            PH_ACK_HIGH: begin scl_lvl = 1'b1; sda_lvl = 1'b1;         end
            PH_ACK_LOW:  begin scl_lvl = 1'b0; sda_lvl = 1'b1;         end
            PH_STOP_A:   begin scl_lvl = 1'b0; sda_lvl = 1'b0;         end
            PH_STOP_B:   begin scl_lvl = 1'b1; sda_lvl = 1'b0;         end
            PH_STOP_C:   begin scl_lvl = 1'b1; sda_lvl = 1'b1;         end
            default:
            begin
                scl_lvl = 1'b1;
                sda_lvl = 1'b1;
                active  = 1'b0;
            end
        endcase
    end

    assign limit    = (phase_ticks_reg == 8'd0) ? 8'd1 : phase_ticks_reg;
    assign wait_inc = wait_count_reg + 8'd1;
    assign bit_inc  = bit_count_reg + 4'd1;
    assign byte_inc = byte_index_reg + 2'd1;

    // Step the sequencer for one item and form its result
    always_comb
    begin
        phase_next        = active ? phase_reg : PH_IDLE;
        byte_index_next   = byte_index_reg;
        bit_count_next    = bit_count_reg;
        shift_next        = shift_reg;
        wait_count_next   = wait_count_reg;
        held_payload_next = held_payload_reg;
        nack_flag_next    = nack_flag_reg;
        result.scl_level  = 1'b1;
        result.sda_level  = 1'b1;
        result.busy_res   = 1'b0;
        result.done_res   = 1'b0;

        if (item.mode)
        begin
            result.busy_res = 1'b1;
            if (!active)
            begin
                // Start a new transaction
                held_payload_next = {item.is_data, item.payload};
                nack_flag_next    = 1'b0;
                byte_index_next   = 2'd0;
                bit_count_next    = 4'd0;
                wait_count_next   = 8'd0;
                shift_next        = address_byte_reg;
                phase_next        = PH_START_A;
            end
            else
            begin
                result.scl_level = scl_lvl;
                result.sda_level = sda_lvl;
            end
        end
        else if (active)
        begin
            result.scl_level = scl_lvl;
            result.sda_level = sda_lvl;
            result.busy_res  = 1'b1;
            if (wait_inc >= limit || wait_inc == 8'd0)
            begin
                wait_count_next = 8'd0;
                // Advance to the next phase
                case (phase_reg)
                    PH_START_A:  phase_next = PH_START_B;
                    PH_START_B:  phase_next = PH_START_C;
                    PH_START_C:
                    begin
                        bit_count_next = 4'd0;
                        phase_next     = PH_BIT_SET;
                    end
                    PH_BIT_SET:  phase_next = PH_BIT_HIGH;
                    PH_BIT_HIGH: phase_next = PH_BIT_LOW;
                    PH_BIT_LOW:
                    begin
                        shift_next     = {shift_reg[6:0], 1'b0};
                        bit_count_next = bit_inc;
                        phase_next     = (bit_inc >= BITS_PER_BYTE) ? PH_ACK_SET
                                                                    : PH_BIT_SET;
                    end
                    PH_ACK_SET:  phase_next = PH_ACK_HIGH;
                    PH_ACK_HIGH:
                    begin
                        if (item.sda_in)
                        begin
                            nack_flag_next = 1'b1;
                        end
                        phase_next = PH_ACK_LOW;
                    end
                    PH_ACK_LOW:
                    begin
                        if (nack_flag_reg || byte_index_reg >= LAST_BYTE)
                        begin
                            phase_next = PH_STOP_A;
                        end
                        else
                        begin
                            byte_index_next = byte_inc;
                            if (byte_inc == 2'd1)
                            begin
                                shift_next = held_payload_reg[8] ? CTRL_DATA
                                                                 : CTRL_COMMAND;
                            end
                            else
                            begin
                                shift_next = held_payload_reg[7:0];
                            end
                            bit_count_next = 4'd0;
                            phase_next     = PH_BIT_SET;
                        end
                    end
                    PH_STOP_A:   phase_next = PH_STOP_B;
                    PH_STOP_B:   phase_next = PH_STOP_C;
                    PH_STOP_C:
                    begin
                        phase_next      = PH_IDLE;
                        result.done_res = 1'b1;
                    end
                    default:     phase_next = PH_IDLE;
                endcase
            end
            else
            begin
                wait_count_next = wait_inc;
            end
        end

        result.nack = nack_flag_next;
    end

    // Sequencer state, updated on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            byte_index_reg   <= 2'd0;
            bit_count_reg    <= 4'd0;
            shift_reg        <= 8'd0;
            wait_count_reg   <= 8'd0;
            held_payload_reg <= 9'd0;
            nack_flag_reg    <= 1'b0;
        end
        else if (item_valid)
        begin
            phase_reg        <= phase_next;
            byte_index_reg   <= byte_index_next;
            bit_count_reg    <= bit_count_next;
            shift_reg        <= shift_next;
            wait_count_reg   <= wait_count_next;
            held_payload_reg <= held_payload_next;
            nack_flag_reg    <= nack_flag_next;
        end
    end

endmodule

FILE: rtl/i2cdbw_skid.sv
// ============================================================================
// I2C display byte writer - result buffer
// Output register with a skid stage; ready toward the input side comes from
// a flop, so the two sides are decoupled.
// ============================================================================
module i2cdbw_skid
    import i2cdbw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_data,
    output logic      can_push,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic      out_valid_reg,  out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t out_data_reg,   out_data_next;
    out_item_t skid_data_reg,  skid_data_next;
    logic      pop;

    assign pop = out_valid_reg && out_ready;

    // Move results through the output and skid stages
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
